// File: rtl/tpcl_pkg.sv
// shared types and constants for the threshold promotion cache list
`timescale 1ns / 1ps

package tpcl_pkg;

    localparam int IN_KEY_WIDTH     = 32;
    localparam int IN_TDATA_WIDTH   = 32;
    localparam int OUT_TDATA_WIDTH  = 72;
    localparam int COUNT_WIDTH      = 16;
    localparam int LIMIT_WIDTH      = 5;
    localparam int POS_OUT_WIDTH    = 4;
    localparam int CFG_INDEX_WIDTH  = 4;
    localparam int CFG_DATA_WIDTH   = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE       = 16'd1;
    localparam logic [COUNT_WIDTH-1:0] THRESHOLD_RESET = 16'd3;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET     = 5'd16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PROMOTE_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAPACITY_LIMIT    = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MATCH  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/tpcl_ctrl.sv
// controller state machine for the threshold promotion cache list
`timescale 1ns / 1ps

module tpcl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  tpcl_pkg::dp_status_t status,
    output tpcl_pkg::ctrl_cmd_t  cmd
);

    tpcl_pkg::state_t state_reg;
    tpcl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpcl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            tpcl_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = tpcl_pkg::ST_MATCH;
                end
            end
            tpcl_pkg::ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = tpcl_pkg::ST_UPDATE;
            end
            tpcl_pkg::ST_UPDATE: begin
                if (status.out_free) begin
                    cmd.update    = 1'b1;
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid) begin
                        cmd.load   = 1'b1;
                        state_next = tpcl_pkg::ST_MATCH;
                    end else begin
                        state_next = tpcl_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tpcl_pkg::ST_IDLE;
            end
        endcase
        // no item is taken while in reset
        if (!aresetn) begin
            s_axis_tready = 1'b0;
            cmd           = '0;
        end
    end

endmodule

// File: rtl/tpcl_datapath.sv
// slot cells, match logic, list update and result register
`timescale 1ns / 1ps

module tpcl_datapath #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  tpcl_pkg::ctrl_cmd_t                     cmd,
    output tpcl_pkg::dp_status_t                    status,
    input  logic [tpcl_pkg::IN_TDATA_WIDTH-1:0]     s_axis_tdata,
    input  logic                                    cfg_valid,
    input  logic [tpcl_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tpcl_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [tpcl_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata
);

    localparam int OCC_WIDTH = $clog2(CAPACITY + 2);
    localparam int POS_WIDTH = $clog2(CAPACITY);
    localparam int SEL_WIDTH = $clog2(CAPACITY + 1);
    localparam int LIM_WIDTH = (OCC_WIDTH > tpcl_pkg::LIMIT_WIDTH) ?
                               OCC_WIDTH : tpcl_pkg::LIMIT_WIDTH;
    localparam int CW        = tpcl_pkg::COUNT_WIDTH;

    // configuration
    logic [CW-1:0]                      threshold_reg;
    logic [tpcl_pkg::LIMIT_WIDTH-1:0]   limit_reg;

    // list cells
    logic [KEY_WIDTH-1:0]   slot_key_reg [CAPACITY];
    logic [CW-1:0]          slot_cnt_reg [CAPACITY];
    logic [OCC_WIDTH-1:0]   occ_reg;

    // match stage
    logic [KEY_WIDTH-1:0]   in_key_reg;
    logic [KEY_WIDTH-1:0]   upd_key_reg;
    logic [CAPACITY-1:0]    match_vec;
    logic [CAPACITY-1:0]    seen;
    logic [CAPACITY-1:0]    first_vec;
    logic [POS_WIDTH-1:0]   pos_enc;
    logic [CAPACITY-1:0]    first_reg;
    logic [CAPACITY-1:0]    upto_reg;
    logic                   hit_reg;
    logic [POS_WIDTH-1:0]   pos_reg;

    // update stage
    logic [CW-1:0]          before_cnt;
    logic [CW-1:0]          new_cnt;
    logic                   promote;
    logic [KEY_WIDTH-1:0]   next_key [CAPACITY+1];
    logic [CW-1:0]          next_cnt [CAPACITY+1];
    logic [OCC_WIDTH-1:0]   occ_new;
    logic [OCC_WIDTH-1:0]   occ_after;
    logic [LIM_WIDTH-1:0]   lim_eff;
    logic                   evict;
    logic [SEL_WIDTH-1:0]   ev_sel;
    logic [KEY_WIDTH-1:0]   ev_key;
    logic [CW-1:0]          ev_cnt;

    logic                                   out_valid_reg;
    logic [tpcl_pkg::OUT_TDATA_WIDTH-1:0]   out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= tpcl_pkg::THRESHOLD_RESET;
            limit_reg     <= tpcl_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                tpcl_pkg::CFG_PROMOTE_THRESHOLD: threshold_reg <= cfg_data;
                tpcl_pkg::CFG_CAPACITY_LIMIT: begin
                    limit_reg <= cfg_data[tpcl_pkg::LIMIT_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    // compare every cell against the key
    for (genvar i = 0; i < CAPACITY; i++) begin : g_match
        assign match_vec[i] = (slot_key_reg[i] == in_key_reg) &&
                              (OCC_WIDTH'(i) < occ_reg);
    end

    always_comb begin
        seen[0] = 1'b0;
        for (int i = 1; i < CAPACITY; i++) begin
            seen[i] = seen[i-1] | match_vec[i-1];
        end
    end

    assign first_vec = match_vec & ~seen;

    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_vec[i]) begin
                pos_enc = pos_enc | POS_WIDTH'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_key_reg <= KEY_WIDTH'(s_axis_tdata[tpcl_pkg::IN_KEY_WIDTH-1:0]);
        end
        if (cmd.match) begin
            upd_key_reg <= in_key_reg;
            first_reg   <= first_vec;
            upto_reg    <= ~seen;
            hit_reg     <= |match_vec;
            pos_reg     <= pos_enc;
        end
    end

    // count of the hit entry
    always_comb begin
        before_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_reg[i]) begin
                before_cnt = before_cnt | slot_cnt_reg[i];
            end
        end
    end

    always_comb begin
        if (!hit_reg) begin
            new_cnt = tpcl_pkg::COUNT_ONE;
        end else if (before_cnt < tpcl_pkg::COUNT_MAX) begin
            new_cnt = before_cnt + tpcl_pkg::COUNT_ONE;
        end else begin
            new_cnt = tpcl_pkg::COUNT_MAX;
        end
    end

    assign promote = hit_reg && (before_cnt >= threshold_reg) && !first_reg[0];

    // next list contents, one extra slot for the entry pushed past the end
    for (genvar i = 0; i <= CAPACITY; i++) begin : g_next
        if (i == 0) begin : g_head
            assign next_key[i] = (!hit_reg || promote) ? upd_key_reg : slot_key_reg[i];
            assign next_cnt[i] = (!hit_reg || promote || first_reg[i]) ?
                                 new_cnt : slot_cnt_reg[i];
        end else if (i < CAPACITY) begin : g_mid
            logic upd_here;
            logic shift_here;
            assign upd_here   = hit_reg && first_reg[i] && !promote;
            assign shift_here = !hit_reg || (promote && upto_reg[i]);
            assign next_key[i] = shift_here ? slot_key_reg[i-1] : slot_key_reg[i];
            assign next_cnt[i] = upd_here   ? new_cnt :
                                 shift_here ? slot_cnt_reg[i-1] : slot_cnt_reg[i];
        end else begin : g_tail
            assign next_key[i] = slot_key_reg[i-1];
            assign next_cnt[i] = slot_cnt_reg[i-1];
        end
    end

    assign occ_new = hit_reg ? occ_reg : occ_reg + OCC_WIDTH'(1);
    assign lim_eff = (LIM_WIDTH'(limit_reg) > LIM_WIDTH'(CAPACITY)) ?
                     LIM_WIDTH'(CAPACITY) : LIM_WIDTH'(limit_reg);
    assign evict     = LIM_WIDTH'(occ_new) > lim_eff;
    assign occ_after = evict ? occ_new - OCC_WIDTH'(1) : occ_new;
    assign ev_sel    = SEL_WIDTH'(occ_new - OCC_WIDTH'(1));

    always_comb begin
        ev_key = '0;
        ev_cnt = '0;
        if (evict) begin
            for (int i = 0; i <= CAPACITY; i++) begin
                if (SEL_WIDTH'(i) == ev_sel) begin
                    ev_key = next_key[i];
                    ev_cnt = next_cnt[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_key_reg[i] <= next_key[i];
                slot_cnt_reg[i] <= next_cnt[i];
            end
            out_data_reg <= {1'b0, ev_cnt, 32'(ev_key), evict, new_cnt,
                             4'(pos_reg), promote, hit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.update) begin
                occ_reg       <= occ_after;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;

endmodule

// File: rtl/threshold_promotion_cache_list.sv
// top level of the threshold promotion cache list
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY keys with saturating hit counts, head first.
// A hit bumps the count and moves the entry to the head once its count before
// the hit reaches promote_threshold; a miss inserts at the head with count 1
// and the tail is evicted when occupancy exceeds capacity_limit (capped at
// CAPACITY). For each item, all cells compare the key in parallel in the match
// state, and in the update state the cells shift and the result register loads.
// The next item is taken in that update state while results are drained; a
// stalled result holds the update. The list is empty after reset, with no
// clearing pass. Config writes (index 0 promote_threshold, index 1
// capacity_limit) are taken every cycle outside reset.

module threshold_promotion_cache_list #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // request_key [31:0]
    input  logic [tpcl_pkg::IN_TDATA_WIDTH-1:0]     s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // was_hit [0], was_promoted [1], hit_position [5:2], entry_count [21:6],
    // did_evict [22], evicted_key [54:23], evicted_count [70:55], zero [71]
    output logic [tpcl_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tpcl_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tpcl_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    tpcl_pkg::ctrl_cmd_t  cmd;
    tpcl_pkg::dp_status_t status;

    assign cfg_ready = aresetn;

    tpcl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    tpcl_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
